### sv/cmac_lea128_tag_macros.svh
// ---------------------------------------------------------------------------
// CMAC-LEA tag assertion macros
// Shared assertion forms for the block's checker.
// ---------------------------------------------------------------------------
`ifndef CMAC_LEA128_TAG_MACROS_SVH
`define CMAC_LEA128_TAG_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cmac_pkg.sv
// ---------------------------------------------------------------------------
// CMAC-LEA package
// Shared types, constants and helper functions for the CMAC tag block.
// ---------------------------------------------------------------------------
package cmac_pkg;

    localparam int Rounds = 24;
    localparam int RndW   = 5;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_TAG_BYTES = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;    // latch the input transaction
        logic load_zero;  // start an encryption of zero
        logic load_data;  // start an encryption of the chained block
        logic round;      // run one round
        logic save_l;     // store cipher output as L
        logic save_chain; // store cipher output as chain value
        logic save_tag;   // store cipher output as tag
    } cmac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rounds_done;
        logic blk_last;
    } cmac_sts_t;

    // Delta constant for index i, the round number modulo 4.
    function automatic logic [31:0] delta(input logic [1:0] i);
        logic [31:0] d;
        unique case (i)
            2'd0: d = 32'hc3efe9db;
            2'd1: d = 32'h44626b02;
            2'd2: d = 32'h79e27c8a;
            default: d = 32'h78df30ec;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    // Byte-reversal turning big-endian byte order into a little-endian word.
    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [127:0] gf_dbl(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ {120'd0, x[127] ? 8'h87 : 8'h00};
    endfunction

endpackage

### sv/cmac_lea128_tag.sv
// ---------------------------------------------------------------------------
// CMAC-LEA tag top level
// CMAC over LEA-128 with a 128-bit key, truncated tag output.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   msg_high, msg_low, byte_count, last
// out       output     out_valid / out_ready tag_high, tag_low
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A block is captured, loaded and run through 24 rounds of the single round unit.
// The first block of a message first encrypts zero to derive the subkey.
// A tag waits in its output register until taken; no new transaction starts
// before that. Reset clears the key, the chain value and the open message.
module cmac_lea128_tag (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] msg_high,
    input  logic [63:0] msg_low,
    input  logic [4:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] tag_high,
    output logic [63:0] tag_low
);

    cmac_pkg::cmac_cmd_t cmd;
    cmac_pkg::cmac_sts_t sts;

    cmac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cmac_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .msg_high   (msg_high),
        .msg_low    (msg_low),
        .byte_count (byte_count),
        .last       (last),
        .cmd        (cmd),
        .sts        (sts),
        .tag_high   (tag_high),
        .tag_low    (tag_low)
    );

endmodule

### sv/cmac_ctrl.sv
// ---------------------------------------------------------------------------
// CMAC-LEA controller
// Sequences subkey setup, block encryption and tag delivery.
// ---------------------------------------------------------------------------
module cmac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cmac_pkg::cmac_sts_t sts,
    output cmac_pkg::cmac_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUBK = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DATA = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   open_reg, open_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (open_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.load_zero = 1'b1;
                        open_next     = 1'b1;
                        state_next    = ST_SUBK;
                    end
                end
            end
            ST_SUBK:
            begin
                cmd.round = 1'b1;
                if (sts.rounds_done)
                begin
                    cmd.save_l = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_data = 1'b1;
                state_next    = ST_DATA;
            end
            ST_DATA:
            begin
                cmd.round = 1'b1;
                if (sts.rounds_done)
                begin
                    if (sts.blk_last)
                    begin
                        cmd.save_tag = 1'b1;
                        open_next    = 1'b0;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        cmd.save_chain = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
        end
    end

endmodule

### sv/cmac_dp.sv
// ---------------------------------------------------------------------------
// CMAC-LEA datapath
// LEA-128 round unit, key schedule, chaining, padding and tag truncation.
// ---------------------------------------------------------------------------
module cmac_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [63:0]         msg_high,
    input  logic [63:0]         msg_low,
    input  logic [4:0]          byte_count,
    input  logic                last,
    input  cmac_pkg::cmac_cmd_t cmd,
    output cmac_pkg::cmac_sts_t sts,
    output logic [63:0]         tag_high,
    output logic [63:0]         tag_low
);

    localparam int RND_W = cmac_pkg::RndW;

    logic [63:0]  key_high_reg, key_low_reg;
    logic [4:0]   tag_bytes_reg;
    logic [127:0] blk_reg, chain_reg, l_reg, tag_reg;
    logic [4:0]   cnt_reg;
    logic         last_reg;
    logic [31:0]  kw_reg [4];
    logic [31:0]  xw_reg [4];
    logic [31:0]  kw_next [4];
    logic [31:0]  xw_next [4];
    logic [RND_W-1:0] rnd_reg;

    logic [127:0] k1, k2, pad, xin, cout, tmask;
    logic [127:0] key_all;
    logic [31:0]  d;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            tag_bytes_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmac_pkg::REG_KEY_HIGH:  key_high_reg  <= cfg_data;
                cmac_pkg::REG_KEY_LOW:   key_low_reg   <= cfg_data;
                cmac_pkg::REG_TAG_BYTES: tag_bytes_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Subkeys and padded last block.
    assign k1 = cmac_pkg::gf_dbl(l_reg);
    assign k2 = cmac_pkg::gf_dbl(k1);
    always_comb
    begin
        pad = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (5'(k) < cnt_reg)
            begin
                pad[127-8*k -: 8] = blk_reg[127-8*k -: 8];
            end
            else if (5'(k) == cnt_reg)
            begin
                pad[127-8*k -: 8] = 8'h80;
            end
        end
    end

    always_comb
    begin
        if (!last_reg)
        begin
            xin = blk_reg ^ chain_reg;
        end
        else if (cnt_reg >= 5'd16)
        begin
            xin = blk_reg ^ k1 ^ chain_reg;
        end
        else
        begin
            xin = pad ^ k2 ^ chain_reg;
        end
    end

    // One LEA round with on-the-fly key schedule.
    assign key_all = {key_high_reg, key_low_reg};
    assign d = cmac_pkg::delta(rnd_reg[1:0]);
    always_comb
    begin
        kw_next[0] = cmac_pkg::rotl(kw_reg[0] + cmac_pkg::rotl(d, rnd_reg), 5'd1);
        kw_next[1] = cmac_pkg::rotl(kw_reg[1] + cmac_pkg::rotl(d, rnd_reg + 5'd1), 5'd3);
        kw_next[2] = cmac_pkg::rotl(kw_reg[2] + cmac_pkg::rotl(d, rnd_reg + 5'd2), 5'd6);
        kw_next[3] = cmac_pkg::rotl(kw_reg[3] + cmac_pkg::rotl(d, rnd_reg + 5'd3), 5'd11);
        xw_next[0] = cmac_pkg::rotl((xw_reg[0] ^ kw_next[0]) + (xw_reg[1] ^ kw_next[1]), 5'd9);
        xw_next[1] = cmac_pkg::rotl((xw_reg[1] ^ kw_next[2]) + (xw_reg[2] ^ kw_next[1]),
                                    5'd27);
        xw_next[2] = cmac_pkg::rotl((xw_reg[2] ^ kw_next[3]) + (xw_reg[3] ^ kw_next[1]),
                                    5'd29);
        xw_next[3] = xw_reg[0];
    end

    // Cipher output is taken from the final round as it completes.
    assign cout = {cmac_pkg::bswap(xw_next[0]), cmac_pkg::bswap(xw_next[1]),
                   cmac_pkg::bswap(xw_next[2]), cmac_pkg::bswap(xw_next[3])};

    assign sts.rounds_done = (rnd_reg == RND_W'(cmac_pkg::Rounds - 1));
    assign sts.blk_last    = last_reg;

    // Round state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
        end
        else if (cmd.load_zero || cmd.load_data)
        begin
            rnd_reg <= '0;
        end
        else if (cmd.round)
        begin
            rnd_reg <= rnd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_zero || cmd.load_data)
        begin
            for (int w = 0; w < 4; w++)
            begin
                kw_reg[w] <= cmac_pkg::bswap(key_all[127-32*w -: 32]);
                xw_reg[w] <= cmd.load_zero ? 32'd0 : cmac_pkg::bswap(xin[127-32*w -: 32]);
            end
        end
        else if (cmd.round)
        begin
            for (int w = 0; w < 4; w++)
            begin
                kw_reg[w] <= kw_next[w];
                xw_reg[w] <= xw_next[w];
            end
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            blk_reg  <= {msg_high, msg_low};
            cnt_reg  <= byte_count;
            last_reg <= last;
        end
    end

    // Chain value, L and tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            l_reg     <= '0;
        end
        else if (cmd.load_zero)
        begin
            chain_reg <= '0;
        end
        else if (cmd.save_chain)
        begin
            chain_reg <= cout;
        end
        else if (cmd.save_tag)
        begin
            chain_reg <= '0;
        end
        else if (cmd.save_l)
        begin
            l_reg <= cout;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            tmask[127-8*k -: 8] = (5'(k) < tag_bytes_reg) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_tag)
        begin
            tag_reg <= cout & tmask;
        end
    end

    assign tag_high = tag_reg[127:64];
    assign tag_low  = tag_reg[63:0];

endmodule

### sv/cmac_chk.sv
// ---------------------------------------------------------------------------
// CMAC-LEA port checker
// Port-level checks on the tag block's transactions.
// ---------------------------------------------------------------------------
`include "cmac_lea128_tag_macros.svh"

module cmac_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] tag_high
);

    // The block never accepts input while a tag is pending.
    `CL_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready, "ready while tag pending")

    // A non-last transaction never yields a tag in the next cycle.
    `CL_ASSERT_NXT(a_nolast, clk, rst_n, in_valid && in_ready && !last, !out_valid,
                   "tag after non-last block")

    // A pending tag holds its value.
    `CL_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(tag_high), "tag changed while stalled")

    // Each accepted input keeps the block busy: no input accepted right after one.
    `CL_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready,
                   "input accepted on back-to-back cycles")

endmodule

bind cmac_lea128_tag cmac_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tag_high  (tag_high)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CMAC-LEA tag testbench
// Drives message blocks through the CMAC tag block under several key and
// tag-length settings and idling patterns, predicts every tag with a
// self-contained LEA-128 CMAC model and compares each output transaction.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CycleLimit = 1500000;
    localparam int SettleCycles = 60;
    localparam int ItemTarget = 1000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] msg_high;
    logic [63:0] msg_low;
    logic [4:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] tag_high;
    logic [63:0] tag_low;

    cmac_lea128_tag uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .msg_high(msg_high), .msg_low(msg_low),
        .byte_count(byte_count), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .tag_high(tag_high), .tag_low(tag_low)
    );

    // Shadow of the configuration registers and the chaining state.
    logic [127:0] key_copy;
    logic [4:0]   tag_len_copy;
    logic [127:0] chain_copy;
    logic [127:0] subkey_copy;
    bit           msg_open;

    logic [127:0] tag_queue[$];
    int           errors;
    int           items_sent;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_req;
    int           hold_seen;
    int           hold_left;

    // Directed stimulus row; a fixed tag is checked in addition to the predictor.
    typedef struct {
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [4:0]   cnt;
        logic         lst;
        logic [4:0]   tlen;
        bit           fixed;
        logic [127:0] fixed_tag;
    } row_t;

    row_t rows[$];

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        int m;
        m = n % 32;
        if (m == 0)
            return x;
        return (x << m) | (x >> (32 - m));
    endfunction

    // Word w holds bytes 4w..4w+3 with the lowest byte in the low bits.
    function automatic logic [31:0] word_of(input logic [127:0] v, input int w);
        logic [31:0] r;
        int j;
        for (j = 0; j < 4; j++)
            r[8*j +: 8] = v[127 - 8*(4*w + j) -: 8];
        return r;
    endfunction

    function automatic logic [127:0] lea_encrypt(input logic [127:0] pt,
                                                 input logic [127:0] key);
        logic [31:0] rk[4];
        logic [31:0] x[4];
        logic [31:0] d, a, b, c;
        logic [127:0] ct;
        int r, w, j;
        for (w = 0; w < 4; w++)
        begin
            rk[w] = word_of(key, w);
            x[w] = word_of(pt, w);
        end
        for (r = 0; r < cmac_pkg::Rounds; r++)
        begin
            case (r % 4)
                0: d = 32'hc3efe9db;
                1: d = 32'h44626b02;
                2: d = 32'h79e27c8a;
                default: d = 32'h78df30ec;
            endcase
            rk[0] = rol32(rk[0] + rol32(d, r), 1);
            rk[1] = rol32(rk[1] + rol32(d, r + 1), 3);
            rk[2] = rol32(rk[2] + rol32(d, r + 2), 6);
            rk[3] = rol32(rk[3] + rol32(d, r + 3), 11);
            a = rol32((x[0] ^ rk[0]) + (x[1] ^ rk[1]), 9);
            b = rol32((x[1] ^ rk[2]) + (x[2] ^ rk[1]), 27);
            c = rol32((x[2] ^ rk[3]) + (x[3] ^ rk[1]), 29);
            x[3] = x[0];
            x[0] = a;
            x[1] = b;
            x[2] = c;
        end
        for (w = 0; w < 4; w++)
            for (j = 0; j < 4; j++)
                ct[127 - 8*(4*w + j) -: 8] = x[w][8*j +: 8];
        return ct;
    endfunction

    function automatic logic [127:0] gf_times2(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    // Advances the CMAC state by one block; returns 1 when a tag results.
    function automatic bit cmac_advance(input logic [127:0] blk, input logic [4:0] cnt,
                                        input logic lst, output logic [127:0] tag);
        logic [127:0] k1, x, pad;
        int k, tl;
        tag = '0;
        if (!msg_open)
        begin
            subkey_copy = lea_encrypt('0, key_copy);
            chain_copy = '0;
            msg_open = 1'b1;
        end
        if (!lst)
        begin
            chain_copy = lea_encrypt(chain_copy ^ blk, key_copy);
            return 1'b0;
        end
        k1 = gf_times2(subkey_copy);
        if (cnt >= 16)
            x = blk ^ k1;
        else
        begin
            pad = '0;
            for (k = 0; k < cnt; k++)
                pad[127 - 8*k -: 8] = blk[127 - 8*k -: 8];
            pad[127 - 8*cnt -: 8] = 8'h80;
            x = pad ^ gf_times2(k1);
        end
        tag = lea_encrypt(x ^ chain_copy, key_copy);
        tl = (tag_len_copy > 16) ? 16 : tag_len_copy;
        for (k = tl; k < 16; k++)
            tag[127 - 8*k -: 8] = 8'h00;
        chain_copy = '0;
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cmac_pkg::REG_KEY_HIGH: key_copy[127:64] = val;
            cmac_pkg::REG_KEY_LOW: key_copy[63:0] = val;
            default: tag_len_copy = val[4:0];
        endcase
    endtask

    // Waits until every tag has come back, then lets the block settle.
    task automatic drain;
        while (tag_queue.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Offers one block and records the predicted tag once it is accepted.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt, input logic lst,
                              output bit got, output logic [127:0] tag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        msg_high <= hi;
        msg_low <= lo;
        byte_count <= cnt;
        last <= lst;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        got = cmac_advance({hi, lo}, cnt, lst, tag);
        if (got)
            tag_queue.push_back(tag);
        items_sent++;
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge_or_rand64;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // Output side: random stalls, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Tag checker.
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tag_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected tag %h%h", $time, tag_high, tag_low);
            end
            else
            begin
                want = tag_queue.pop_front();
                if (tag_high !== want[127:64])
                begin
                    errors++;
                    $display("%0t: tag_high expected %h actual %h",
                             $time, want[127:64], tag_high);
                end
                if (tag_low !== want[63:0])
                begin
                    errors++;
                    $display("%0t: tag_low expected %h actual %h",
                             $time, want[63:0], tag_low);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic row_t mk(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [4:0] cnt, input logic lst,
                                input logic [4:0] tlen, input bit fixed);
        row_t r;
        r.hi = hi;
        r.lo = lo;
        r.cnt = cnt;
        r.lst = lst;
        r.tlen = tlen;
        r.fixed = fixed;
        r.fixed_tag = '0;
        return r;
    endfunction

    initial
    begin
        bit got;
        logic [127:0] tag;
        int i, nblk, b, phase;
        logic [4:0] tl;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cmac_pkg::REG_KEY_HIGH;
        cfg_data = '0;
        in_valid = 1'b0;
        msg_high = '0;
        msg_low = '0;
        byte_count = '0;
        last = 1'b0;
        out_ready = 1'b0;
        errors = 0;
        items_sent = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        key_copy = '0;
        tag_len_copy = 5'd16;
        chain_copy = '0;
        subkey_copy = '0;
        msg_open = 1'b0;

        // Directed table: empty message, full and short blocks, saturated
        // count, empty last after data, tag lengths zero, one and above 16.
        rows.push_back(mk('0, '0, 5'd0, 1'b1, 5'd16, 0));
        rows.push_back(mk('0, '0, 5'd16, 1'b1, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd16, 1'b1, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd15, 1'b1, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd1, 1'b1, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd31, 1'b1, 5'd16, 0));
        rows.push_back(mk(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd3, 1'b0, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd31, 1'b0, 5'd16, 0));
        rows.push_back(mk('1, '0, 5'd0, 1'b1, 5'd16, 0));
        rows.push_back(mk('1, '1, 5'd16, 1'b1, 5'd0, 1));
        rows.push_back(mk('0, '0, 5'd0, 1'b1, 5'd0, 1));
        rows.push_back(mk('0, '1, 5'd8, 1'b1, 5'd1, 0));
        rows.push_back(mk('1, '0, 5'd7, 1'b1, 5'd31, 0));
        rows.push_back(mk('1, '1, 5'd0, 1'b0, 5'd17, 0));
        rows.push_back(mk('0, '0, 5'd9, 1'b1, 5'd17, 0));
        rows.push_back(mk(64'h8000000000000001, 64'h8000000000000001, 5'd16, 1'b1, 5'd8, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            if (!msg_open && rows[i].tlen != tag_len_copy)
            begin
                // Withdraw the accepted transaction before idling.
                in_valid <= 1'b0;
                drain();
                write_reg(cmac_pkg::REG_TAG_BYTES, {59'd0, rows[i].tlen});
            end
            send_block(rows[i].hi, rows[i].lo, rows[i].cnt, rows[i].lst, got, tag);
            if (got && rows[i].fixed && tag !== rows[i].fixed_tag)
            begin
                errors++;
                $display("%0t: row %0d expected %h predicted %h",
                         $time, i, rows[i].fixed_tag, tag);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Random phases, each with its own key, tag length and idling pattern.
        phase = 0;
        while (items_sent < ItemTarget)
        begin
            drain();
            case ($urandom_range(4))
                0: tl = 5'd0;
                1: tl = 5'd16;
                2: tl = 5'd31;
                default: tl = 5'($urandom_range(31));
            endcase
            write_reg(cmac_pkg::REG_KEY_HIGH, edge_or_rand64());
            write_reg(cmac_pkg::REG_KEY_LOW, edge_or_rand64());
            write_reg(cmac_pkg::REG_TAG_BYTES, {59'd0, tl});
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 71; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 71; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (phase == 2 || phase == 9)
                hold_req = hold_req + 1;
            repeat (12)
            begin
                nblk = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
                for (b = 1; b <= nblk; b++)
                    send_block(edge_or_rand64(), edge_or_rand64(), 5'($urandom_range(31)),
                               b == nblk, got, tag);
            end
            in_valid <= 1'b0;
            @(posedge clk);
            phase++;
        end

        drain();
        if (errors == 0 && tag_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
